// ----- hw/rtl/pcs_pkg.sv -----
// ----------------------------------------------------------------------------
// PLL coefficient search package
// Field widths, fixed constants and the running-best record that travels
// along the cell chain.
// ----------------------------------------------------------------------------
package pcs_pkg;

   // Field widths
   localparam int TARGET_W    = 19;
   localparam int REF_W       = 4;
   localparam int FB_W        = 8;
   localparam int POST_W      = 4;
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = REF_W + FB_W + POST_W;

   // Fixed reference clock and feedback multiplier limit
   localparam int unsigned REF_CLK_KHZ = 27000;
   localparam int unsigned FB_MAX      = 255;

   // Search range defaults
   localparam int MAX_POST_DIV_DEF = 8;
   localparam int MAX_REF_DIV_DEF  = 13;

   // Register stages from a cell's target input to its compare stage
   localparam int CELL_DEPTH = 4;

   // Best candidate found so far for one word in flight
   typedef struct packed {
      logic                valid;
      logic                have;
      logic [TARGET_W-1:0] err;
      logic [REF_W-1:0]    m;
      logic [FB_W-1:0]     n;
      logic [POST_W-1:0]   p;
   } best_type;

endpackage

// ----- hw/rtl/pll_coefficient_search.sv -----
// ----------------------------------------------------------------------------
// PLL coefficient search
// The path from accepted word to output register runs through the chain of one
// cell per (M, P) pair plus the four arithmetic stages inside a cell.
// Throughput: one word per cycle when not stalled; the whole chain advances on one enable.
// Reset clears the valid flags only; no clearing pass is needed.
// ----------------------------------------------------------------------------
module pll_coefficient_search #(
   parameter int MAX_POST_DIV = pcs_pkg::MAX_POST_DIV_DEF,
   parameter int MAX_REF_DIV  = pcs_pkg::MAX_REF_DIV_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // target_khz [18:0], zero fill above
   input  logic [pcs_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // ref_divider [3:0], feedback_mult [11:4], post_divider [15:12]
   output logic [pcs_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready
);

   localparam int NUM_CELLS = MAX_POST_DIV * MAX_REF_DIV;
   localparam int TW        = pcs_pkg::TARGET_W;

   logic                          advance;
   logic [TW-1:0]                 tgt_chain  [NUM_CELLS+1];
   pcs_pkg::best_type             best_chain [NUM_CELLS+1];
   pcs_pkg::best_type             head_best;
   logic [pcs_pkg::CELL_DEPTH-1:0] head_ff;
   pcs_pkg::best_type             last;
   logic                          out_valid_ff;
   logic [pcs_pkg::RSP_TDATA_W-1:0] out_data_ff;

   assign last = best_chain[NUM_CELLS];

   // The chain moves unless a finished word meets a full, stalled output
   assign advance    = !last.valid || !out_valid_ff || rsp_tready;
   assign req_tready = advance && !reset;

   // Valid flag delayed to line up with the first cell's compare stage
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
      end else if (advance) begin
         head_ff <= {head_ff[pcs_pkg::CELL_DEPTH-2:0], req_tvalid};
      end
   end

   // Chain head: target from the request word, empty best defaulting to 1, 1, 1
   assign tgt_chain[0] = req_tdata[TW-1:0];

   always_comb begin
      head_best.valid = head_ff[pcs_pkg::CELL_DEPTH-1];
      head_best.have  = 1'b0;
      head_best.err   = '0;
      head_best.m     = pcs_pkg::REF_W'(1);
      head_best.n     = pcs_pkg::FB_W'(1);
      head_best.p     = pcs_pkg::POST_W'(1);
   end

   assign best_chain[0] = head_best;

   // One cell per pair, P in the outer order and M in the inner order
   for (genvar gp = 0; gp < MAX_POST_DIV; gp++) begin : g_post
      for (genvar gm = 0; gm < MAX_REF_DIV; gm++) begin : g_ref
         localparam int K = gp * MAX_REF_DIV + gm;
         pcs_cell #(
            .M_VAL (gm + 1),
            .P_VAL (gp + 1)
         ) u_cell (
            .clock    (clock),
            .reset    (reset),
            .advance  (advance),
            .tgt_in   (tgt_chain[K]),
            .best_in  (best_chain[K]),
            .tgt_out  (tgt_chain[K+1]),
            .best_out (best_chain[K+1])
         );
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && last.valid) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && last.valid) begin
         out_data_ff <= {last.p, last.n, last.m};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

// ----- hw/rtl/pcs_cell.sv -----
// ----------------------------------------------------------------------------
// PLL coefficient search cell
// Evaluates one fixed (M, P) pair for the word passing by: N is the target
// scaled by M*P over the reference, the achieved clock is the reference times
// N over M*P, both divisions done by exact reciprocal multiplication. The
// result is merged into the running best handed on from the previous cell.
// ----------------------------------------------------------------------------
module pcs_cell #(
   parameter int M_VAL = 1,
   parameter int P_VAL = 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic [pcs_pkg::TARGET_W-1:0] tgt_in,
   input  pcs_pkg::best_type           best_in,
   output logic [pcs_pkg::TARGET_W-1:0] tgt_out,
   output pcs_pkg::best_type           best_out
);

   localparam int TW     = pcs_pkg::TARGET_W;
   localparam int MP     = M_VAL * P_VAL;
   localparam int MP_W   = $clog2(MP + 1);
   localparam int PROD_W = TW + MP_W;
   // Reciprocal of the reference clock, exact for every product below 2**PROD_W
   localparam int L1     = $clog2(pcs_pkg::REF_CLK_KHZ);
   localparam int S1     = PROD_W + L1;
   localparam int R1_W   = PROD_W + 1;
   localparam logic [63:0] R1 =
      ((64'd1 << S1) + 64'(pcs_pkg::REF_CLK_KHZ) - 64'd1) / 64'(pcs_pkg::REF_CLK_KHZ);
   localparam int M1_W   = PROD_W + R1_W;
   localparam int NQ_W   = PROD_W - L1 + 1;
   localparam int NQX_W  = (NQ_W > pcs_pkg::FB_W) ? NQ_W : pcs_pkg::FB_W;
   // Reciprocal of M*P, exact for every numerator below 2**NUM_W
   localparam int NUM_W  = pcs_pkg::FB_W + L1;
   localparam int L2     = $clog2(MP);
   localparam int S2     = NUM_W + L2;
   localparam int R2_W   = NUM_W + 1;
   localparam logic [63:0] R2 = ((64'd1 << S2) + 64'(MP) - 64'd1) / 64'(MP);
   localparam int M2_W   = NUM_W + R2_W;

   // Stage registers
   logic [TW-1:0]             tgt_ff, tgt_a_ff, tgt_b_ff, tgt_c_ff, tgt_d_ff;
   logic [PROD_W-1:0]         prod_ff, prod_in;
   logic [NQ_W-1:0]           nq_ff, nq_in;
   logic [NUM_W-1:0]          num_ff, num_in;
   logic [pcs_pkg::FB_W-1:0]  n_c_ff, n_c_in, n_d_ff;
   logic                      ok_c_ff, ok_c_in, ok_d_ff;
   logic [TW-1:0]             got_ff, got_in;
   pcs_pkg::best_type         best_ff, best_in_sel;

   logic [M1_W-1:0]           mul1;
   logic [M2_W-1:0]           mul2;
   logic [NQX_W-1:0]          nq_wide;
   logic [TW-1:0]             err;

   // Stage A: target times M*P
   assign prod_in = PROD_W'(tgt_in) * PROD_W'(MP);

   // Stage B: divide by the reference clock
   assign mul1  = M1_W'(prod_ff) * M1_W'(R1[R1_W-1:0]);
   assign nq_in = NQ_W'(mul1 >> S1);

   // Stage C: range check on N and the numerator of the achieved clock
   assign nq_wide = NQX_W'(nq_ff);
   assign ok_c_in = (nq_wide >= NQX_W'(1)) && (nq_wide <= NQX_W'(pcs_pkg::FB_MAX));
   assign n_c_in  = pcs_pkg::FB_W'(nq_wide);
   assign num_in  = NUM_W'(n_c_in) * NUM_W'(pcs_pkg::REF_CLK_KHZ);

   // Stage D: divide by M*P; the achieved clock never exceeds the target
   assign mul2   = M2_W'(num_ff) * M2_W'(R2[R2_W-1:0]);
   assign got_in = TW'(mul2 >> S2);

   // Stage E: keep the first candidate with the smallest error
   assign err = tgt_d_ff - got_ff;

   always_comb begin
      best_in_sel = best_in;
      if (ok_d_ff && (!best_in.have || (err < best_in.err))) begin
         best_in_sel.have = 1'b1;
         best_in_sel.err  = err;
         best_in_sel.m    = pcs_pkg::REF_W'(M_VAL);
         best_in_sel.n    = n_d_ff;
         best_in_sel.p    = pcs_pkg::POST_W'(P_VAL);
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (advance) begin
         tgt_ff   <= tgt_in;
         tgt_a_ff <= tgt_in;
         prod_ff  <= prod_in;
         tgt_b_ff <= tgt_a_ff;
         nq_ff    <= nq_in;
         tgt_c_ff <= tgt_b_ff;
         num_ff   <= num_in;
         n_c_ff   <= n_c_in;
         ok_c_ff  <= ok_c_in;
         tgt_d_ff <= tgt_c_ff;
         got_ff   <= got_in;
         n_d_ff   <= n_c_ff;
         ok_d_ff  <= ok_c_ff;
      end
   end

   // Running best; only its valid flag is control state
   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff.valid <= 1'b0;
      end else if (advance) begin
         best_ff <= best_in_sel;
      end
   end

   assign tgt_out  = tgt_ff;
   assign best_out = best_ff;

endmodule
